FILE: rtl/tilt_gesture_detector_core_assert.svh
// Assertion macros for the tilt gesture detector.
// Needs aclk and aresetn in the scope of the module that takes this header.
`ifndef TILT_GESTURE_DETECTOR_CORE_ASSERT_SVH
`define TILT_GESTURE_DETECTOR_CORE_ASSERT_SVH

// Check that cond holds in the same cycle as trig.
`define TGD_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error("tilt gesture detector: same-cycle check failed");

// Check that cond holds in the cycle after trig.
`define TGD_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error("tilt gesture detector: next-cycle check failed");

`endif

FILE: rtl/tgd_pkg.sv
// Shared types, phase and direction codes and register map of the tilt
// gesture detector. No dependencies.
package tgd_pkg;

    localparam int unsigned ACCEL_W   = 16;
    localparam int unsigned TICK_W    = 32;
    localparam int unsigned LEVEL_W   = 15;
    localparam int unsigned PHASE_W   = 4;
    localparam int unsigned DIR_W     = 3;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned APB_AW    = 4;

    // Machine phases
    localparam logic [PHASE_W-1:0] PH_RESET       = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START       = 4'd1;
    localparam logic [PHASE_W-1:0] PH_CLASSIFY    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_DWELL_UP    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_DWELL_DOWN  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_DWELL_LEFT  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_DWELL_RIGHT = 4'd6;
    localparam logic [PHASE_W-1:0] PH_ACTIVE_UP   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_ACTIVE_DOWN = 4'd8;
    localparam logic [PHASE_W-1:0] PH_ACTIVE_LEFT = 4'd9;
    localparam logic [PHASE_W-1:0] PH_ACTIVE_RIGHT = 4'd10;
    localparam logic [PHASE_W-1:0] PH_SETTLE      = 4'd11;

    // Distance from a dwell phase to its active phase
    localparam logic [PHASE_W-1:0] PH_DWELL_TO_ACTIVE = PH_ACTIVE_UP - PH_DWELL_UP;

    // Reported directions
    localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;

    // Active phase minus this offset gives the reported direction
    localparam logic [PHASE_W-1:0] ACTIVE_DIR_BASE = PH_ACTIVE_UP - PHASE_W'(DIR_UP);

    // Direction index inside the dwell and active phase groups
    localparam logic [1:0] AXIS_UP    = 2'd0;
    localparam logic [1:0] AXIS_DOWN  = 2'd1;
    localparam logic [1:0] AXIS_LEFT  = 2'd2;
    localparam logic [1:0] AXIS_RIGHT = 2'd3;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_DWELL   = 2'd0;
    localparam logic [1:0] REG_ENTER   = 2'd1;
    localparam logic [1:0] REG_RELEASE = 2'd2;

    localparam logic [TICK_W-1:0]  DWELL_RESET   = 32'd10000;
    localparam logic [LEVEL_W-1:0] ENTER_RESET   = 15'd2662;
    localparam logic [LEVEL_W-1:0] RELEASE_RESET = 15'd2048;

    typedef struct packed {
        logic signed [ACCEL_W-1:0] accel_x;
        logic signed [ACCEL_W-1:0] accel_y;
        logic [TICK_W-1:0]         now_ticks;
    } in_item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [DIR_W-1:0]   active_direction;
        logic               new_gesture;
    } out_item_t;

    typedef struct packed {
        logic [TICK_W-1:0]  dwell_ticks;
        logic [LEVEL_W-1:0] enter_level;
        logic [LEVEL_W-1:0] release_level;
    } cfg_t;

    // Next state of the machine for one transfer
    typedef struct packed {
        logic [PHASE_W-1:0] next_phase;
        logic               load_start;
        out_item_t          result;
    } step_t;

endpackage

FILE: rtl/tilt_gesture_detector_core.sv
// Top level of the tilt gesture detector: stream ports, APB registers, state.
// Depends on tgd_pkg, tgd_regs, tgd_step and tilt_gesture_detector_core_assert.svh.

// Each transfer on the s_ channel is one accelerometer poll (X, Y in signed
// fixed point with 4096 = 1 g, plus a free-running tick count) and yields
// exactly one result on the m_ channel: the phase after the poll, the active
// direction (0 none, 1 up, 2 down, 3 left, 4 right) and a one-poll
// new_gesture pulse. A poll is taken every cycle that s_ready is high: the
// phase update is a few signed compares and one 32-bit wrapping subtraction
// between the input port and the result register, so each result appears in
// the next cycle. s_ready stays high while the result register is empty or
// is being drained in the same cycle, so a waiting result never blocks the
// next poll unless the downstream side stalls. Registers at byte address 0
// (dwell_ticks), 4 (enter_level) and 8 (release_level) are written over APB;
// write them only while no poll is in flight. The dwell time counts from the
// tick of the poll taken in the start phase, and the subtraction wraps, so a
// tick count that runs backwards reads as a long dwell.
`include "tilt_gesture_detector_core_assert.svh"

module tilt_gesture_detector_core
    import tgd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // poll input
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    // result output
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t               cfg;
    step_t              step;
    logic               s_xfer;

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [TICK_W-1:0]  start_time_reg;
    logic [TICK_W-1:0]  start_time_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    out_item_t          m_data_reg;
    out_item_t          m_data_next;

    assign pready = 1'b1;

    tgd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    tgd_step u_step (
        .phase      (phase_reg),
        .start_time (start_time_reg),
        .item       (s_data),
        .cfg        (cfg),
        .step       (step)
    );

    // Accept a poll whenever the result slot is free or drains this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        phase_next      = phase_reg;
        start_time_next = start_time_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            // drop the delivered result
            m_valid_next = 1'b0;
        end
        if (s_xfer) begin
            // advance the machine and load the result slot
            phase_next   = step.next_phase;
            m_data_next  = step.result;
            m_valid_next = 1'b1;
            if (step.load_start) begin
                start_time_next = s_data.now_ticks;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_RESET;
            start_time_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            start_time_reg <= start_time_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Result payload needs no reset: hold it until the next transfer
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The reported phase always matches the machine state right after a transfer
    `TGD_ASSERT_NEXT(a_phase_tracks_state, s_xfer, m_valid && (m_data.phase == phase_reg))
    // The machine moves only on an accepted poll
    `TGD_ASSERT_NEXT(a_phase_holds_idle, !s_xfer, $stable(phase_reg))
    // A new gesture always comes with an active direction
    `TGD_ASSERT_SAME(a_gesture_has_dir, m_valid && m_data.new_gesture, m_data.active_direction != DIR_NONE)

endmodule

FILE: rtl/tgd_regs.sv
// APB register file of the tilt gesture detector: dwell time and levels.
// Depends on tgd_pkg.
module tgd_regs
    import tgd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_DWELL:   cfg_next.dwell_ticks   = pwdata[TICK_W-1:0];
                REG_ENTER:   cfg_next.enter_level   = pwdata[LEVEL_W-1:0];
                REG_RELEASE: cfg_next.release_level = pwdata[LEVEL_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dwell_ticks   <= DWELL_RESET;
            cfg_reg.enter_level   <= ENTER_RESET;
            cfg_reg.release_level <= RELEASE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DWELL:   prdata = cfg_reg.dwell_ticks;
            REG_ENTER:   prdata = {{(APB_DW-LEVEL_W){1'b0}}, cfg_reg.enter_level};
            REG_RELEASE: prdata = {{(APB_DW-LEVEL_W){1'b0}}, cfg_reg.release_level};
            default:     prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/tgd_step.sv
// Next-phase logic of the tilt gesture detector for one poll.
// Depends on tgd_pkg.
module tgd_step
    import tgd_pkg::*;
(
    input  logic [PHASE_W-1:0] phase,
    input  logic [TICK_W-1:0]  start_time,
    input  in_item_t           item,
    input  cfg_t               cfg,
    output step_t              step
);

    logic signed [ACCEL_W:0] x_ext;
    logic signed [ACCEL_W:0] y_ext;
    logic signed [ACCEL_W:0] ent_pos;
    logic signed [ACCEL_W:0] ent_neg;
    logic signed [ACCEL_W:0] rel_pos;
    logic signed [ACCEL_W:0] rel_neg;
    logic                    x_band;
    logic                    y_band;
    logic [PHASE_W-1:0]      grp_off;
    logic                    let_go;
    logic [TICK_W-1:0]       elapsed;
    logic                    dwell_done;
    logic [PHASE_W-1:0]      np;
    logic                    newg;
    logic                    load_start;
    logic [PHASE_W-1:0]      dir_raw;

    // Widen by one bit so the negated levels and the inputs share a range
    assign x_ext   = {item.accel_x[ACCEL_W-1], item.accel_x};
    assign y_ext   = {item.accel_y[ACCEL_W-1], item.accel_y};
    assign ent_pos = {2'b00, cfg.enter_level};
    assign rel_pos = {2'b00, cfg.release_level};
    assign ent_neg = -ent_pos;
    assign rel_neg = -rel_pos;

    assign x_band = (x_ext > rel_neg) && (x_ext < rel_pos);
    assign y_band = (y_ext > rel_neg) && (y_ext < rel_pos);

    // Low two bits of (phase - 3) give the axis for dwell and active phases alike
    assign grp_off = phase - PH_DWELL_UP;

    always_comb begin
        unique case (grp_off[1:0])
            AXIS_UP:    let_go = y_ext > rel_neg;
            AXIS_DOWN:  let_go = y_ext < rel_pos;
            AXIS_LEFT:  let_go = x_ext > rel_neg;
            AXIS_RIGHT: let_go = x_ext < rel_pos;
            default:    let_go = 1'b0;
        endcase
    end

    assign elapsed    = item.now_ticks - start_time;
    assign dwell_done = elapsed > cfg.dwell_ticks;

    always_comb begin
        np         = PH_RESET;
        newg       = 1'b0;
        load_start = 1'b0;
        unique case (phase)
            PH_RESET: np = PH_START;
            PH_START: begin
                np         = PH_CLASSIFY;
                load_start = 1'b1;
            end
            PH_CLASSIFY: begin
                priority if (y_ext < ent_neg && x_band) np = PH_DWELL_UP;
                else if (y_ext > ent_pos && x_band)     np = PH_DWELL_DOWN;
                else if (x_ext < ent_neg && y_band)     np = PH_DWELL_LEFT;
                else if (x_ext > ent_pos && y_band)     np = PH_DWELL_RIGHT;
                else                                    np = PH_RESET;
            end
            PH_DWELL_UP, PH_DWELL_DOWN, PH_DWELL_LEFT, PH_DWELL_RIGHT: begin
                priority if (let_go) begin
                    np = PH_RESET;
                end else if (dwell_done) begin
                    np   = phase + PH_DWELL_TO_ACTIVE;
                    newg = 1'b1;
                end else begin
                    np = phase;
                end
            end
            PH_ACTIVE_UP, PH_ACTIVE_DOWN, PH_ACTIVE_LEFT, PH_ACTIVE_RIGHT:
                np = let_go ? PH_SETTLE : phase;
            PH_SETTLE: np = PH_RESET;
            default:   np = PH_RESET;
        endcase
    end

    assign dir_raw = np - ACTIVE_DIR_BASE;

    always_comb begin
        step.next_phase         = np;
        step.load_start         = load_start;
        step.result.phase       = np;
        step.result.new_gesture = newg;
        if (np >= PH_ACTIVE_UP && np <= PH_ACTIVE_RIGHT) begin
            step.result.active_direction = dir_raw[DIR_W-1:0];
        end else begin
            step.result.active_direction = DIR_NONE;
        end
    end

endmodule

FILE: verif/tilt_gesture_detector_core_tb.sv
// Self-checking testbench for tilt_gesture_detector_core: polls in, phase results out.
// Depends on tgd_pkg and the core; keeps its own copy of the tilt machine to predict results.

module tilt_gesture_detector_core_tb;
    import tgd_pkg::*;

    // Index past the end of the register map; a write there must change nothing
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    in_item_t          s_data;
    logic              m_valid;
    logic              m_ready;
    out_item_t         m_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Shadow of the machine and its registers, advanced on every accepted poll
    logic [PHASE_W-1:0] tilt_phase  = PH_RESET;
    logic [TICK_W-1:0]  tick_origin = '0;
    logic [TICK_W-1:0]  dwell_cfg   = DWELL_RESET;
    logic [LEVEL_W-1:0] enter_cfg   = ENTER_RESET;
    logic [LEVEL_W-1:0] release_cfg = RELEASE_RESET;

    out_item_t          predicted_results[$];
    int                 mismatch_count = 0;
    bit                 no_idle = 1'b0;
    logic [TICK_W-1:0]  tick_now = '0;

    tilt_gesture_detector_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // True once the axis of a held tilt has come back past the release level
    function automatic bit axis_released(logic [1:0] axis, int x, int y, int rel);
        case (axis)
            AXIS_UP:   return y > -rel;
            AXIS_DOWN: return y < rel;
            AXIS_LEFT: return x > -rel;
            default:   return x < rel;
        endcase
    endfunction

    // Advance the shadow machine by one poll and return the result it must produce
    function automatic out_item_t advance_tilt_machine(in_item_t poll);
        int                 x;
        int                 y;
        int                 ent;
        int                 rel;
        bit                 x_band;
        bit                 y_band;
        logic [PHASE_W-1:0] cur;
        logic [PHASE_W-1:0] nxt;
        logic               pulse;
        logic [TICK_W-1:0]  elapsed;
        out_item_t          res;
        x       = $signed(poll.accel_x);
        y       = $signed(poll.accel_y);
        ent     = int'(enter_cfg);
        rel     = int'(release_cfg);
        x_band  = (x > -rel) && (x < rel);
        y_band  = (y > -rel) && (y < rel);
        cur     = tilt_phase;
        pulse   = 1'b0;
        elapsed = poll.now_ticks - tick_origin;
        case (cur)
            PH_RESET: nxt = PH_START;
            PH_START: begin
                // dwell counts from this poll, not from the classify poll
                tick_origin = poll.now_ticks;
                nxt = PH_CLASSIFY;
            end
            PH_CLASSIFY: begin
                if (y < -ent && x_band)
                    nxt = PH_DWELL_UP;
                else if (y > ent && x_band)
                    nxt = PH_DWELL_DOWN;
                else if (x < -ent && y_band)
                    nxt = PH_DWELL_LEFT;
                else if (x > ent && y_band)
                    nxt = PH_DWELL_RIGHT;
                else
                    nxt = PH_RESET;
            end
            PH_DWELL_UP, PH_DWELL_DOWN, PH_DWELL_LEFT, PH_DWELL_RIGHT: begin
                if (axis_released(2'(cur - PH_DWELL_UP), x, y, rel)) begin
                    nxt = PH_RESET;
                end else if (elapsed > dwell_cfg) begin
                    nxt   = cur + PH_DWELL_TO_ACTIVE;
                    pulse = 1'b1;
                end else begin
                    nxt = cur;
                end
            end
            PH_ACTIVE_UP, PH_ACTIVE_DOWN, PH_ACTIVE_LEFT, PH_ACTIVE_RIGHT: begin
                nxt = axis_released(2'(cur - PH_ACTIVE_UP), x, y, rel) ? PH_SETTLE : cur;
            end
            default: nxt = PH_RESET;
        endcase
        tilt_phase = nxt;
        res.phase = nxt;
        res.active_direction = (nxt >= PH_ACTIVE_UP && nxt <= PH_ACTIVE_RIGHT) ?
                               DIR_W'(nxt - ACTIVE_DIR_BASE) : DIR_NONE;
        res.new_gesture = pulse;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Poll construction
    // ------------------------------------------------------------------

    function automatic logic signed [ACCEL_W-1:0] clip16(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[ACCEL_W-1:0];
    endfunction

    // Land a couple of counts either side of a threshold
    function automatic int near_level(int lvl);
        return lvl - 2 + int'($urandom_range(0, 4));
    endfunction

    function automatic in_item_t make_poll(int x, int y, logic [TICK_W-1:0] t);
        in_item_t p;
        p.accel_x   = clip16(x);
        p.accel_y   = clip16(y);
        p.now_ticks = t;
        return p;
    endfunction

    // Build a tilt along one axis: held past the levels, or let go toward center
    function automatic in_item_t make_tilt(logic [1:0] axis, bit hold, logic [TICK_W-1:0] t);
        int mag;
        int side;
        int rel;
        int ent;
        rel = int'(release_cfg);
        ent = int'(enter_cfg);
        if (hold) begin
            case ($urandom_range(0, 3))
                0:       mag = near_level(ent);
                1:       mag = near_level(rel);
                2:       mag = int'($urandom_range(0, 32768));
                default: mag = 32768;
            endcase
        end else begin
            case ($urandom_range(0, 1))
                0:       mag = near_level(rel);
                default: mag = int'($urandom_range(0, rel));
            endcase
        end
        case ($urandom_range(0, 2))
            0:       side = near_level(rel);
            1:       side = int'($urandom_range(0, rel));
            default: side = 0;
        endcase
        if ($urandom_range(0, 1) != 0)
            side = -side;
        case (axis)
            AXIS_UP:   return make_poll(side, -mag, t);
            AXIS_DOWN: return make_poll(side, mag, t);
            AXIS_LEFT: return make_poll(-mag, side, t);
            default:   return make_poll(mag, side, t);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    task automatic flag_mismatch(string what);
        mismatch_count++;
        // cap the log so a badly broken build stays readable
        if (mismatch_count <= 200)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Send one poll: idle a random gap, hold valid until the transfer, then predict
    task automatic send_poll(in_item_t poll);
        int gap;
        if ($urandom_range(0, 29) == 0)
            no_idle = !no_idle;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= poll;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted_results.push_back(advance_tilt_machine(poll));
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        // the register takes the value at this edge
        case (idx)
            REG_DWELL:   dwell_cfg   = value;
            REG_ENTER:   enter_cfg   = value[LEVEL_W-1:0];
            REG_RELEASE: release_cfg = value[LEVEL_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_register(logic [1:0] idx);
        logic [APB_DW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        got = prdata;
        case (idx)
            REG_DWELL: begin
                if (got !== dwell_cfg)
                    flag_mismatch($sformatf("dwell_ticks reads %h, want %h", got, dwell_cfg));
            end
            REG_ENTER: begin
                if (got[LEVEL_W-1:0] !== enter_cfg)
                    flag_mismatch($sformatf("enter_level reads %h, want %h",
                                            got[LEVEL_W-1:0], enter_cfg));
            end
            default: begin
                if (got[LEVEL_W-1:0] !== release_cfg)
                    flag_mismatch($sformatf("release_level reads %h, want %h",
                                            got[LEVEL_W-1:0], release_cfg));
            end
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Change all three registers between bursts and read them back
    task automatic apply_setting(logic [31:0] dwell, logic [31:0] enter_w, logic [31:0] rel_w);
        wait_for_idle();
        write_register(REG_DWELL, dwell);
        write_register(REG_ENTER, enter_w);
        write_register(REG_RELEASE, rel_w);
        check_register(REG_DWELL);
        check_register(REG_ENTER);
        check_register(REG_RELEASE);
    endtask

    // Mostly well-formed gestures steered by the shadow phase, the rest raw noise
    task automatic run_random_polls(int count);
        int                 r;
        logic [TICK_W-1:0]  step;
        logic [PHASE_W-1:0] cur;
        in_item_t           poll;
        // pace the tick count so a held tilt crosses the dwell in a few polls
        step = (dwell_cfg > 32'h0FFF_FFFF) ? 32'h0FFF_FFFF : dwell_cfg / 3 + 2;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 49);
            if (r == 0)
                tick_now = 32'hFFFF_FFFF - $urandom_range(0, step);
            else if (r == 1)
                tick_now = tick_now - $urandom_range(1, 50);
            else
                tick_now = tick_now + $urandom_range(0, step);
            cur = tilt_phase;
            if ($urandom_range(0, 4) == 0) begin
                poll = {$urandom, $urandom};
            end else begin
                case (cur)
                    PH_CLASSIFY: begin
                        poll = make_tilt(2'($urandom_range(0, 3)), $urandom_range(0, 5) != 0,
                                         tick_now);
                    end
                    PH_DWELL_UP, PH_DWELL_DOWN, PH_DWELL_LEFT, PH_DWELL_RIGHT: begin
                        // sit right on the dwell boundary now and then
                        if ($urandom_range(0, 3) == 0)
                            tick_now = tick_origin + dwell_cfg + $urandom_range(0, 1);
                        poll = make_tilt(2'(cur - PH_DWELL_UP), $urandom_range(0, 5) != 0,
                                         tick_now);
                    end
                    PH_ACTIVE_UP, PH_ACTIVE_DOWN, PH_ACTIVE_LEFT, PH_ACTIVE_RIGHT: begin
                        poll = make_tilt(2'(cur - PH_ACTIVE_UP), $urandom_range(0, 3) != 0,
                                         tick_now);
                    end
                    default: poll = {$urandom, tick_now};
                endcase
            end
            send_poll(poll);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Stall the result channel a random number of cycles before each transfer
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // Compare every result transfer against the oldest prediction
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (predicted_results.size() == 0) begin
                flag_mismatch("result transfer with no poll pending");
            end else begin
                want = predicted_results.pop_front();
                if (m_data.phase !== want.phase)
                    flag_mismatch($sformatf("phase %0d, want %0d", m_data.phase, want.phase));
                if (m_data.active_direction !== want.active_direction)
                    flag_mismatch($sformatf("active_direction %0d, want %0d",
                                            m_data.active_direction, want.active_direction));
                if (m_data.new_gesture !== want.new_gesture)
                    flag_mismatch($sformatf("new_gesture %b, want %b",
                                            m_data.new_gesture, want.new_gesture));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values, truncation of the level registers, and the unmapped slot
    task automatic test_register_map();
        check_register(REG_DWELL);
        check_register(REG_ENTER);
        check_register(REG_RELEASE);
        write_register(REG_DWELL, 32'hFFFF_FFFF);
        write_register(REG_ENTER, 32'hFFFF_7FFF);
        write_register(REG_RELEASE, 32'h1234_0000);
        write_register(REG_UNMAPPED, $urandom);
        check_register(REG_DWELL);
        check_register(REG_ENTER);
        check_register(REG_RELEASE);
    endtask

    // Up and left gestures, dwell from the start tick, wrap, backward ticks, an early
    // release of a down tilt, and a tilt short of the enter level
    task automatic test_directed_polls();
        apply_setting(32'd5, 32'd2662, 32'd2048);
        no_idle = 1'b1;
        send_poll(make_poll(32767, -32768, 32'd0));          // reset -> start
        send_poll(make_poll(0, 0, 32'd100));                 // start tick 100
        send_poll(make_poll(2047, -2663, 32'd101));          // up
        send_poll(make_poll(0, -2048, 32'd105));             // elapsed equals dwell: hold
        send_poll(make_poll(0, -2048, 32'd106));             // active up
        send_poll(make_poll(0, -32768, 32'd0));
        send_poll(make_poll(0, -2047, 32'd0));               // release -> settle
        send_poll(make_poll(-32768, 32767, 32'd0));
        send_poll(make_poll(0, 0, 32'hFFFF_FFFE));           // start near the wrap
        send_poll(make_poll(-2047, 2663, 32'hFFFF_FFFF));    // start tick FFFF_FFFF
        send_poll(make_poll(0, 32767, 32'd4));               // down
        send_poll(make_poll(0, 2047, 32'd4));
        send_poll(make_poll(0, 0, 32'd4));
        send_poll(make_poll(0, 0, 32'd1000));
        send_poll(make_poll(-2663, 2047, 32'd1000));         // left
        send_poll(make_poll(-32768, 0, 32'd999));            // tick runs backward
        send_poll(make_poll(-2047, 0, 32'd999));
        send_poll(make_poll(0, 0, 32'd999));
        send_poll(make_poll(0, 0, 32'd50));
        send_poll(make_poll(2663, -2047, 32'd50));           // start tick 50
        send_poll(make_poll(2047, 0, 32'd60));               // short of the enter level: back to reset
        send_poll(make_poll(0, 0, 32'd0));
        send_poll(make_poll(2663, 2048, 32'd0));             // start tick 0
        no_idle = 1'b0;
    endtask

    task automatic test_random_short_dwell();
        apply_setting(32'd20, 32'd2662, 32'd2048);
        run_random_polls(220);
    endtask

    task automatic test_random_reset_levels();
        apply_setting(DWELL_RESET, 32'(ENTER_RESET), 32'(RELEASE_RESET));
        run_random_polls(130);
    endtask

    // Zero dwell with the widest band, then the longest dwell with an empty band
    task automatic test_random_extremes();
        apply_setting(32'd0, 32'd0, 32'h0000_7FFF);
        run_random_polls(70);
        apply_setting(32'hFFFF_FFFF, 32'h0000_7FFF, 32'd0);
        run_random_polls(50);
    endtask

    task automatic test_random_mixed_levels();
        apply_setting($urandom_range(0, 64), $urandom_range(0, 4000), $urandom_range(2000, 8000));
        run_random_polls(60);
        apply_setting($urandom_range(0, 64), $urandom, $urandom);
        run_random_polls(60);
        apply_setting($urandom_range(0, 64), $urandom_range(3000, 9000), $urandom_range(0, 3000));
        run_random_polls(60);
    endtask

    initial begin
        aclk    = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_map();
        test_directed_polls();
        test_random_short_dwell();
        test_random_reset_levels();
        test_random_extremes();
        test_random_mixed_levels();

        // drain, then wait so that stray results can still show up
        wait_for_idle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hard stop in case a handshake hangs
    initial begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
